// ===== hdl/sldf_pkg.sv =====
// sldf_pkg: constants and the result type shared by the deframer modules
// no dependencies
`timescale 1ns / 1ps

package sldf_pkg;

    // sync mark and header layout
    localparam logic [7:0]  SYNC_BYTE  = 8'hFD;
    localparam logic [1:0]  SYNC_LAST  = 2'd3;
    localparam int          POS_W      = 17;
    localparam logic [16:0] POS_START  = 17'd4;
    localparam logic [16:0] POS_TYPE   = 17'd5;
    localparam logic [16:0] POS_LEN0   = 17'd6;
    localparam logic [16:0] POS_LEN1   = 17'd7;
    localparam logic [16:0] POS_LEN2   = 17'd8;
    localparam logic [16:0] HEADER_LEN = 17'd9;

    // configuration reset value
    localparam logic [15:0] MAX_PAYLOAD_RESET = 16'd1000;

    // one result transaction
    typedef struct packed {
        logic        payload_valid;
        logic [7:0]  payload_byte;
        logic        frame_done;
        logic        frame_good;
        logic [7:0]  frame_type;
        logic [15:0] frame_length;
        logic        length_error;
        logic        resynced;
    } result_t;

endpackage

// ===== hdl/sync_length_checksum_deframer.sv =====
// sync_length_checksum_deframer: top level of the sync/length/checksum deframer
// depends on sldf_pkg, sldf_in_stage, sldf_parser, sldf_out_stage
//
// Usage:
//   s_ channel: one received byte per transaction (s_valid/s_ready).
//   m_ channel: one result per received byte (m_valid/m_ready): payload byte
//     pass-through, frame done/good flags, current type and length, length
//     abort and resync flags.
//   cfg_wr_en/cfg_wr_data write max_payload; write only while idle.
//   Path: an accepted byte is held in the input register, then passes through
//     the parse logic into the result register, which drives the m_ channel.
//   Throughput: one byte per cycle unless stalled; the frame state is updated
//     in the same cycle a byte moves from input register to result register.
//   Stall: when m_ready is low the result register holds, the next byte waits
//     in the input register, and s_ready drops once both are full.
//   Reset: synchronous, active low; clears the frame state, both stages and
//     sets max_payload to 1000. No clearing pass, ready right after reset.
`timescale 1ns / 1ps

module sync_length_checksum_deframer
    import sldf_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_rx_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_payload_valid,
    output logic [7:0]  m_payload_byte,
    output logic        m_frame_done,
    output logic        m_frame_good,
    output logic [7:0]  m_frame_type,
    output logic [15:0] m_frame_length,
    output logic        m_length_error,
    output logic        m_resynced
);

    logic       byte_valid;
    logic [7:0] byte_data;
    logic       can_load;
    logic       advance;
    result_t    step_result;
    result_t    out_result;

    // a byte moves on when the result register has room
    assign advance = byte_valid & can_load;

    sldf_in_stage u_in_stage (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_rx_byte  (s_rx_byte),
        .pop        (advance),
        .byte_valid (byte_valid),
        .byte_data  (byte_data)
    );

    sldf_parser u_parser (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .step        (advance),
        .rx_byte     (byte_data),
        .result      (step_result)
    );

    sldf_out_stage u_out_stage (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (advance),
        .load_data (step_result),
        .can_load  (can_load),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (out_result)
    );

    // result fields to ports
    assign m_payload_valid = out_result.payload_valid;
    assign m_payload_byte  = out_result.payload_byte;
    assign m_frame_done    = out_result.frame_done;
    assign m_frame_good    = out_result.frame_good;
    assign m_frame_type    = out_result.frame_type;
    assign m_frame_length  = out_result.frame_length;
    assign m_length_error  = out_result.length_error;
    assign m_resynced      = out_result.resynced;

endmodule

// ===== hdl/sldf_in_stage.sv =====
// sldf_in_stage: input register for received bytes
// uses sldf_pkg (nothing beyond the timescale convention)
`timescale 1ns / 1ps

module sldf_in_stage
    import sldf_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_rx_byte,
    input  logic       pop,
    output logic       byte_valid,
    output logic [7:0] byte_data
);

    logic       valid_reg;
    logic [7:0] data_reg;

    // free when empty or when the held byte moves on this cycle
    assign s_ready    = ~valid_reg | pop;
    assign byte_valid = valid_reg;
    assign byte_data  = data_reg;

    // valid flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_ready) begin
            valid_reg <= s_valid;
        end
    end

    // byte register
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            data_reg <= s_rx_byte;
        end
    end

endmodule

// ===== hdl/sldf_parser.sv =====
// sldf_parser: frame state and per-byte parse logic, max payload register
// depends on sldf_pkg for header constants and result_t
`timescale 1ns / 1ps

module sldf_parser
    import sldf_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,
    input  logic        step,
    input  logic [7:0]  rx_byte,
    output result_t     result
);

    logic [15:0]      max_payload_reg;
    logic [1:0]       sync_run_reg,    sync_run_next;
    logic             in_frame_reg,    in_frame_next;
    logic [POS_W-1:0] byte_pos_reg,    byte_pos_next;
    logic [7:0]       type_reg,        type_next;
    logic [15:0]      length_reg,      length_next;
    logic             length_high_reg, length_high_next;
    logic [15:0]      sum_reg,         sum_next;
    logic [7:0]       prev_byte_reg,   prev_byte_next;

    logic             is_sync;
    logic [POS_W-1:0] pos;
    logic [POS_W-1:0] last_payload;
    logic             too_long;

    assign is_sync      = (rx_byte == SYNC_BYTE);
    assign pos          = byte_pos_reg + POS_W'(1);
    assign last_payload = {1'b0, length_reg} + HEADER_LEN;
    assign too_long     = length_high_reg | (rx_byte != 8'd0) | (length_reg > max_payload_reg);

    // parse one byte
    always_comb begin
        sync_run_next    = sync_run_reg;
        in_frame_next    = in_frame_reg;
        byte_pos_next    = byte_pos_reg;
        type_next        = type_reg;
        length_next      = length_reg;
        length_high_next = length_high_reg;
        sum_next         = sum_reg;
        prev_byte_next   = prev_byte_reg;
        result           = '0;

        if (is_sync && sync_run_reg == SYNC_LAST) begin
            // sync mark complete: start a new frame
            result.resynced  = in_frame_reg;
            in_frame_next    = 1'b1;
            byte_pos_next    = POS_START;
            sync_run_next    = 2'd0;
            sum_next         = 16'd0;
            type_next        = 8'd0;
            length_next      = 16'd0;
            length_high_next = 1'b0;
        end else begin
            sync_run_next = is_sync ? sync_run_reg + 2'd1 : 2'd0;
            if (in_frame_reg) begin
                byte_pos_next = pos;
                if (pos == POS_TYPE) begin
                    type_next = rx_byte;
                end else if (pos == POS_LEN0) begin
                    length_next[7:0] = rx_byte;
                end else if (pos == POS_LEN1) begin
                    length_next[15:8] = rx_byte;
                end else if (pos == POS_LEN2) begin
                    length_high_next = length_high_reg | (rx_byte != 8'd0);
                end else if (pos == HEADER_LEN) begin
                    length_high_next = length_high_reg | (rx_byte != 8'd0);
                    if (too_long) begin
                        result.length_error = 1'b1;
                        in_frame_next       = 1'b0;
                        byte_pos_next       = '0;
                        sync_run_next       = 2'd0;
                        sum_next            = 16'd0;
                    end
                end else if (pos > HEADER_LEN) begin
                    if (pos <= last_payload) begin
                        // payload byte
                        result.payload_valid = 1'b1;
                        result.payload_byte  = rx_byte;
                        sum_next             = sum_reg + {8'd0, rx_byte};
                    end else if (pos == last_payload + POS_W'(1)) begin
                        // low checksum byte
                        prev_byte_next = rx_byte;
                    end else begin
                        // high checksum byte closes the frame
                        result.frame_done = 1'b1;
                        result.frame_good = (sum_reg == {rx_byte, prev_byte_reg});
                        in_frame_next     = 1'b0;
                        byte_pos_next     = '0;
                        sync_run_next     = 2'd0;
                        sum_next          = 16'd0;
                    end
                end
            end
        end

        result.frame_type   = type_next;
        result.frame_length = length_next;
    end

    // configuration register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_payload_reg <= MAX_PAYLOAD_RESET;
        end else if (cfg_wr_en) begin
            max_payload_reg <= cfg_wr_data;
        end
    end

    // frame state, advanced once per transaction
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sync_run_reg    <= 2'd0;
            in_frame_reg    <= 1'b0;
            byte_pos_reg    <= '0;
            type_reg        <= 8'd0;
            length_reg      <= 16'd0;
            length_high_reg <= 1'b0;
            sum_reg         <= 16'd0;
            prev_byte_reg   <= 8'd0;
        end else if (step) begin
            sync_run_reg    <= sync_run_next;
            in_frame_reg    <= in_frame_next;
            byte_pos_reg    <= byte_pos_next;
            type_reg        <= type_next;
            length_reg      <= length_next;
            length_high_reg <= length_high_next;
            sum_reg         <= sum_next;
            prev_byte_reg   <= prev_byte_next;
        end
    end

endmodule

// ===== hdl/sldf_out_stage.sv =====
// sldf_out_stage: result register toward the downstream receiver
// depends on sldf_pkg for result_t
`timescale 1ns / 1ps

module sldf_out_stage
    import sldf_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    load,
    input  result_t load_data,
    output logic    can_load,
    output logic    m_valid,
    input  logic    m_ready,
    output result_t m_data
);

    logic    valid_reg;
    result_t data_reg;

    // room when empty or when the held result is taken this cycle
    assign can_load = ~valid_reg | m_ready;
    assign m_valid  = valid_reg;
    assign m_data   = data_reg;

    // valid flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (can_load) begin
            valid_reg <= load;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= load_data;
        end
    end

endmodule
